[rtl/core/bdwr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bdwr_pkg;

   localparam int MAX_BLOCKS_ACROSS = 1024;
   localparam int MAX_BLOCKS_DOWN   = 1024;

   localparam int COL_W   = $clog2(MAX_BLOCKS_ACROSS);
   localparam int ROW_W   = $clog2(MAX_BLOCKS_DOWN);
   localparam int DIM_W   = 11;
   localparam int VAL_W   = 31;
   localparam int TOTAL_W = 52;
   localparam int MAXB_W  = 34;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAIR_MODE     = 2'd0,
      CSR_BLOCKS_ACROSS = 2'd1,
      CSR_BLOCKS_DOWN   = 2'd2
   } csr_index_type;

   // one entry on its way from the window stage to the accumulators
   typedef struct packed {
      logic              frame_end;
      logic              cand_ok;
      logic [MAXB_W-1:0] cand;
      logic [VAL_W-1:0]  cur;
   } acc_item_type;

   // zero counts as one, anything above the line buffer size as the size
   function automatic logic [COL_W:0] clamp_across(input logic [DIM_W-1:0] v);
      int unsigned t;
      t = 32'(v);
      if (t < 1) t = 1;
      if (t > MAX_BLOCKS_ACROSS) t = MAX_BLOCKS_ACROSS;
      return (COL_W+1)'(t);
   endfunction

   function automatic logic [ROW_W:0] clamp_down(input logic [DIM_W-1:0] v);
      int unsigned t;
      t = 32'(v);
      if (t < 1) t = 1;
      if (t > MAX_BLOCKS_DOWN) t = MAX_BLOCKS_DOWN;
      return (ROW_W+1)'(t);
   endfunction

endpackage
`default_nettype wire

[rtl/core/bdwr_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface bdwr_req_if;
   import bdwr_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] diff_value;
   logic [VAL_W-1:0] part_max;

   modport source (output valid, output diff_value, output part_max, input ready);
   modport sink   (input valid, input diff_value, input part_max, output ready);
endinterface
`default_nettype wire

[rtl/core/bdwr_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface bdwr_rsp_if;
   import bdwr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [TOTAL_W-1:0]       frame_total;
   logic signed [MAXB_W-1:0] max_block;

   modport source (output valid, output frame_total, output max_block, input ready);
   modport sink   (input valid, input frame_total, input max_block, output ready);
endinterface
`default_nettype wire

[rtl/core/bdwr_line_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
module bdwr_line_buf (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [bdwr_pkg::COL_W-1:0] wr_addr,
   input  wire logic [bdwr_pkg::VAL_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [bdwr_pkg::COL_W-1:0] rd_addr,
   output      logic [bdwr_pkg::VAL_W-1:0] rd_data
);
   import bdwr_pkg::*;

   logic [VAL_W-1:0] mem [MAX_BLOCKS_ACROSS];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-before-write on a shared address: old data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[rtl/core/bdwr_accum.sv]
`timescale 1ns / 1ps
`default_nettype none
module bdwr_accum (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire bdwr_pkg::acc_item_type in_item,
   output      logic                   in_ready,
   bdwr_rsp_if.source                  rsp_chan
);
   import bdwr_pkg::*;

   logic               s2_valid_ff, s2_valid_in;
   acc_item_type       s2_item_ff;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [MAXB_W-1:0]  max_ff, max_in;
   logic               max_none_ff, max_none_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic [MAXB_W-1:0]  rsp_max_ff;

   logic               out_free, s2_fire, s2_ready;
   logic [TOTAL_W:0]   sum_wide;
   logic [TOTAL_W-1:0] total_next;
   logic               take_cand;
   logic [MAXB_W-1:0]  max_next;
   logic               none_next;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s2_fire  = s2_valid_ff && (!s2_item_ff.frame_end || out_free);
   assign s2_ready = !s2_valid_ff || s2_fire;
   assign in_ready = s2_ready;

   always_comb begin
      sum_wide   = {1'b0, total_ff} + (TOTAL_W+1)'(s2_item_ff.cur);
      total_next = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
      take_cand  = s2_item_ff.cand_ok && (max_none_ff || (s2_item_ff.cand > max_ff));
      max_next   = take_cand ? s2_item_ff.cand : max_ff;
      none_next  = max_none_ff && !take_cand;

      s2_valid_in  = (in_valid && s2_ready) || (s2_valid_ff && !s2_fire);
      total_in     = total_ff;
      max_in       = max_ff;
      max_none_in  = max_none_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (s2_fire) begin
         if (s2_item_ff.frame_end) begin
            total_in     = '0;
            max_none_in  = 1'b1;
            rsp_valid_in = 1'b1;
         end else begin
            total_in    = total_next;
            max_in      = max_next;
            max_none_in = none_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         total_ff     <= '0;
         max_ff       <= '0;
         max_none_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         total_ff     <= total_in;
         max_ff       <= max_in;
         max_none_ff  <= max_none_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s2_ready) begin
         s2_item_ff <= in_item;
      end
      if (s2_fire && s2_item_ff.frame_end) begin
         rsp_total_ff <= total_next;
         rsp_max_ff   <= none_next ? '1 : max_next;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.frame_total = rsp_total_ff;
   assign rsp_chan.max_block   = signed'(rsp_max_ff);
endmodule
`default_nettype wire

[rtl/core/block_diff_window_reduce_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Frame difference reduction. Half-block difference values of one frame arrive in raster
// order, one transaction per entry, and one result leaves after the last entry of the frame:
// the saturating total of all entries and the largest 2x2 window sum (grid mode) or the
// largest partial maximum (pair mode), -1 when no window exists. One entry is taken every
// clock cycle; only a result held back by the sink stalls the input. The result passes through
// the input register with line buffer read, then the accumulator stage register holding the
// window sum, then the result register. The previous grid row is held in a 1024 x 31 line
// buffer with one write and one read port, which needs no clearing after reset. Set
// pair_mode, blocks_across and blocks_down between frames.
module block_diff_window_reduce_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [bdwr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bdwr_pkg::CSR_DATA_W-1:0] csr_wdata,
   bdwr_req_if.sink                            req_chan,
   bdwr_rsp_if.source                          rsp_chan
);
   import bdwr_pkg::*;

   logic             pair_mode_ff;
   logic [DIM_W-1:0] blocks_across_ff, blocks_down_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             s1_valid_ff, s1_valid_in;
   logic [VAL_W-1:0] s1_cur_ff, s1_pmax_ff;
   logic             s1_pair_ff, s1_win_ok_ff, s1_frame_end_ff;
   logic [VAL_W-1:0] left_ff, upper_left_ff;

   logic [COL_W:0]   across_eff;
   logic [ROW_W:0]   down_eff;
   logic             row_end, frame_end, accept;
   logic [VAL_W-1:0] above;
   logic [MAXB_W-1:0] window;
   logic             s2_ready, s1_move;
   acc_item_type     s1_item;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_mode_ff     <= 1'b0;
         blocks_across_ff <= DIM_W'(1);
         blocks_down_ff   <= DIM_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PAIR_MODE:     pair_mode_ff     <= csr_wdata[0];
            CSR_BLOCKS_ACROSS: blocks_across_ff <= csr_wdata;
            CSR_BLOCKS_DOWN:   blocks_down_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // raster position
   assign across_eff = clamp_across(blocks_across_ff);
   assign down_eff   = clamp_down(blocks_down_ff);
   assign row_end    = ({1'b0, col_ff} + (COL_W+1)'(1)) >= across_eff;
   assign frame_end  = row_end && (({1'b0, row_ff} + (ROW_W+1)'(1)) >= down_eff);

   assign req_chan.ready = !s1_valid_ff || s2_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign s1_move        = s1_valid_ff && s2_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      s1_valid_in = accept || (s1_valid_ff && !s2_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         // neighbours follow grid entries in order as they leave the input stage
         if (s1_move && !s1_pair_ff) begin
            left_ff       <= s1_cur_ff;
            upper_left_ff <= above;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff       <= req_chan.diff_value;
         s1_pmax_ff      <= req_chan.part_max;
         s1_pair_ff      <= pair_mode_ff;
         s1_win_ok_ff    <= (row_ff != '0) && (col_ff != '0);
         s1_frame_end_ff <= frame_end;
      end
   end

   // the same column of the previous row was written at an earlier edge, never the same one
   bdwr_line_buf u_line_buf (
      .clock   (clock),
      .wr_en   (accept && !pair_mode_ff),
      .wr_addr (col_ff),
      .wr_data (req_chan.diff_value),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above)
   );

   always_comb begin
      window = MAXB_W'(upper_left_ff) + MAXB_W'(above) + MAXB_W'(left_ff)
             + MAXB_W'(s1_cur_ff);
      s1_item.frame_end = s1_frame_end_ff;
      s1_item.cand_ok   = s1_pair_ff || s1_win_ok_ff;
      s1_item.cand      = s1_pair_ff ? MAXB_W'(s1_pmax_ff) : window;
      s1_item.cur       = s1_cur_ff;
   end

   bdwr_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_item  (s1_item),
      .in_ready (s2_ready),
      .rsp_chan (rsp_chan)
   );
endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import bdwr_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned ITEM_TARGET   = 1350;
   localparam int unsigned IDLE_PCT      = 32;
   localparam int unsigned REPORT_LIMIT  = 10;

   localparam logic [VAL_W-1:0] VAL_TOP   = '1;
   localparam logic [TOTAL_W:0] TOTAL_TOP = {1'b0, {TOTAL_W{1'b1}}};

   typedef struct packed {
      logic [VAL_W-1:0] diff;
      logic [VAL_W-1:0] pmax;
   } diff_entry_t;

   typedef struct packed {
      logic [TOTAL_W-1:0]       total;
      logic signed [MAXB_W-1:0] peak;
   } frame_summary_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_sel = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   bdwr_req_if req_chan ();
   bdwr_rsp_if rsp_chan ();

   block_diff_window_reduce_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_sel),
      .csr_wdata (csr_data),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // register copies as written through the CSR port
   bit                  mode_pair  = 1'b0;
   logic [DIM_W-1:0]    across_reg = 11'd1;
   logic [DIM_W-1:0]    down_reg   = 11'd1;

   // frame reduction state
   logic [VAL_W-1:0]        line_copy [MAX_BLOCKS_ACROSS];
   logic [VAL_W-1:0]        left_q   = '0;
   logic [VAL_W-1:0]        upleft_q = '0;
   int unsigned             col_idx  = 0;
   int unsigned             row_idx  = 0;
   logic [TOTAL_W:0]        sum_acc  = '0;
   logic signed [MAXB_W:0]  peak_acc = '1;

   diff_entry_t    entries_pending[$];
   frame_summary_t results_due[$];

   int unsigned queued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned fault_count    = 0;
   int unsigned frames_seen    = 0;
   int unsigned pair_frames    = 0;
   int unsigned results_seen   = 0;
   int unsigned csr_writes     = 0;
   int unsigned widest         = 1;
   int unsigned tallest        = 1;
   int unsigned cycle_count    = 0;
   bit          steady         = 1'b0;

   function automatic int unsigned span_of(input logic [DIM_W-1:0] v, input int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return 32'(v);
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return '0;
         1: return VAL_TOP;
         2: return VAL_W'($urandom_range(15));
         3: return VAL_TOP - VAL_W'($urandom_range(15));
         default: return VAL_W'($urandom());
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(19))
         0: return '0;
         1: return 11'd1;
         2: return DIM_W'($urandom_range(9, 40));
         default: return DIM_W'($urandom_range(1, 8));
      endcase
   endfunction

   // fold one entry into the frame; closes is set on the frame's last entry
   task automatic reduce_entry(input logic [VAL_W-1:0] cur, input logic [VAL_W-1:0] pmax,
                               output bit closes, output frame_summary_t summary);
      int unsigned wide;
      int unsigned tall;
      logic [VAL_W-1:0] above;
      logic [MAXB_W:0] window;
      bit row_done;
      wide = span_of(across_reg, MAX_BLOCKS_ACROSS);
      tall = span_of(down_reg, MAX_BLOCKS_DOWN);
      row_done = (col_idx + 1 >= wide);
      sum_acc = sum_acc + (TOTAL_W+1)'(cur);
      if (sum_acc > TOTAL_TOP) sum_acc = TOTAL_TOP;
      if (mode_pair) begin
         if ($signed({4'b0, pmax}) > peak_acc) peak_acc = $signed({4'b0, pmax});
      end else begin
         above = line_copy[COL_W'(col_idx)];
         if (row_idx > 0 && col_idx > 0) begin
            window = (MAXB_W+1)'(upleft_q) + (MAXB_W+1)'(above)
                   + (MAXB_W+1)'(left_q) + (MAXB_W+1)'(cur);
            if ($signed(window) > peak_acc) peak_acc = $signed(window);
         end
         upleft_q = above;
         left_q = cur;
         line_copy[COL_W'(col_idx)] = cur;
      end
      closes = row_done && (row_idx + 1 >= tall);
      summary.total = sum_acc[TOTAL_W-1:0];
      summary.peak = peak_acc[MAXB_W-1:0];
      if (closes) begin
         col_idx = 0;
         row_idx = 0;
         sum_acc = '0;
         peak_acc = '1;
         frames_seen++;
         if (mode_pair) pair_frames++;
      end else if (row_done) begin
         col_idx = 0;
         row_idx++;
      end else begin
         col_idx++;
      end
   endtask

   task automatic flag_fault(input string what, input longint want_v, input longint got_v);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("ERROR: %s: expected %0d, got %0d", what, want_v, got_v);
   endtask

   // driver
   always @(posedge clock) begin : drive_req
      diff_entry_t nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.diff_value <= '0;
         req_chan.part_max <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (entries_pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = entries_pending.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.diff_value <= nxt.diff;
            req_chan.part_max <= nxt.pmax;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor: predicts on accepted entries, checks accepted results
   always @(posedge clock) begin : watch
      frame_summary_t want;
      bit closes;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            reduce_entry(req_chan.diff_value, req_chan.part_max, closes, want);
            accepted_count++;
            if (closes) results_due = {results_due, want};
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("ERROR: result with none outstanding: frame_total %0d max_block %0d",
                           rsp_chan.frame_total, longint'(rsp_chan.max_block));
            end else begin
               want = results_due.pop_front();
               if (rsp_chan.frame_total !== want.total)
                  flag_fault("frame_total", longint'(want.total), longint'(rsp_chan.frame_total));
               if (rsp_chan.max_block !== want.peak)
                  flag_fault("max_block", longint'(want.peak), longint'(rsp_chan.max_block));
            end
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: timed out after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (accepted_count != queued_count || results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_sel <= idx;
      csr_data <= v;
      csr_writes++;
      case (idx)
         CSR_PAIR_MODE:     mode_pair = v[0];
         CSR_BLOCKS_ACROSS: across_reg = v;
         CSR_BLOCKS_DOWN:   down_reg = v;
         default: ;
      endcase
   endtask

   // only between frames, once the block has gone quiet
   task automatic reconfigure(input bit pair, input logic [DIM_W-1:0] across,
                              input logic [DIM_W-1:0] down);
      wait_drained();
      write_csr(CSR_PAIR_MODE, CSR_DATA_W'(pair));
      write_csr(CSR_BLOCKS_ACROSS, across);
      write_csr(CSR_BLOCKS_DOWN, down);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (span_of(across, MAX_BLOCKS_ACROSS) > widest) widest = span_of(across, MAX_BLOCKS_ACROSS);
      if (span_of(down, MAX_BLOCKS_DOWN) > tallest) tallest = span_of(down, MAX_BLOCKS_DOWN);
   endtask

   task automatic queue_entry(input logic [VAL_W-1:0] diff, input logic [VAL_W-1:0] pmax);
      diff_entry_t e;
      e.diff = diff;
      e.pmax = pmax;
      entries_pending = {entries_pending, e};
      queued_count++;
   endtask

   task automatic queue_frames(input int unsigned frames);
      int unsigned count;
      count = frames * span_of(across_reg, MAX_BLOCKS_ACROSS) * span_of(down_reg, MAX_BLOCKS_DOWN);
      repeat (count) queue_entry(pick_value(), pick_value());
   endtask

   initial begin : stimulus
      int unsigned phase;
      phase = 0;
      foreach (line_copy[i]) line_copy[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // 2x2 grid: largest possible window, then alternating bit patterns
      reconfigure(1'b0, 11'd2, 11'd2);
      repeat (4) queue_entry(VAL_TOP, VAL_TOP);
      queue_entry(31'h2AAAAAAA, 31'h55555555);
      queue_entry(31'h55555555, 31'h2AAAAAAA);
      queue_entry(31'h55555555, '0);
      queue_entry(31'h2AAAAAAA, VAL_TOP);
      // single row and single column: no window, max stays at -1
      reconfigure(1'b0, 11'd3, 11'd1);
      queue_entry(31'd7, '0);
      queue_entry('0, VAL_TOP);
      queue_entry(VAL_TOP, 31'd1);
      reconfigure(1'b0, 11'd1, 11'd3);
      queue_entry(VAL_TOP, '0);
      queue_entry(VAL_TOP, '0);
      queue_entry('0, VAL_TOP);
      // pair mode with the partial max at both ends
      reconfigure(1'b1, 11'd2, 11'd2);
      queue_entry(VAL_TOP, '0);
      queue_entry('0, VAL_TOP);
      queue_entry(31'd5, 31'd3);
      queue_entry('0, '0);
      // zero sizes count as one
      reconfigure(1'b1, 11'd0, 11'd0);
      queue_entry(31'd1, '0);
      reconfigure(1'b0, 11'd0, 11'd0);
      queue_entry(VAL_TOP, VAL_TOP);

      while (queued_count < ITEM_TARGET || phase < 8) begin
         phase++;
         if (phase == 3) begin
            // width above the line buffer size, clamped to it; run without idling
            reconfigure(1'b0, 11'd2047, 11'd1);
            steady = 1'b1;
            queue_frames(1);
         end else if (phase == 6) begin
            // tall single column
            reconfigure(1'($urandom_range(1)), 11'd0, 11'd96);
            steady = 1'b0;
            queue_frames(1);
         end else begin
            reconfigure($urandom_range(2) == 0, pick_dim(), pick_dim());
            steady = ($urandom_range(7) == 0);
            queue_frames($urandom_range(1, 4));
         end
      end
      wait_drained();

      $display("Covered %0d entries in %0d frames (%0d pair mode), grids up to %0d x %0d",
               accepted_count, frames_seen, pair_frames, widest, tallest);
      $display("%0d register writes, %0d results checked", csr_writes, results_seen);
      if (fault_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
